FILE: sv/lfifo_pkg.sv
// Shared types and codes for the line FIFO with truncating pop.
`timescale 1ns / 1ps

package lfifo_pkg;

    // Item kinds on the input channel
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_PARAM = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;
    localparam logic [1:0] STATUS_EMPTY = 2'd3;

    // Widths fixed by the port fields, and upper bounds of the slot/offset ranges
    localparam int FIELD_LEN_W = 7;
    localparam int SLOT_W_MAX  = 8;
    localparam int OFF_W_MAX   = 6;

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    // Streams in flight: queue entries plus the one being read out
    localparam int PEND_W     = 2;

    typedef logic [FIELD_LEN_W-1:0] len_t;
    typedef logic [SLOT_W_MAX-1:0]  slot_ext_t;
    typedef logic [OFF_W_MAX-1:0]   off_ext_t;

    // Work item handed from front to back
    typedef struct packed {
        logic      stream;   // 1: read out count bytes of slot, 0: single status result
        logic [1:0] status;
        slot_ext_t slot;
        len_t      count;
        logic      q_empty;
        logic      q_full;
    } cmd_t;

    // Line store write request from front
    typedef struct packed {
        logic      en;
        slot_ext_t slot;
        off_ext_t  off;
        logic [7:0] data;
    } mem_wr_t;

    // Result metadata travelling with a memory read
    typedef struct packed {
        logic [1:0] status;
        logic       byte_valid;
        logic       last;
        len_t       len;
        logic       q_empty;
        logic       q_full;
    } res_t;

endpackage

FILE: sv/lfifo_front.sv
// Front end: accepts items, assembles lines, keeps queue pointers, issues commands.
`timescale 1ns / 1ps

module lfifo_front #(
    parameter int QUEUE_DEPTH = 8,
    parameter int LINE_BYTES  = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 kind,
    input  logic [7:0]           push_byte,
    input  logic                 push_last,
    input  logic [6:0]           pop_limit,
    output lfifo_pkg::mem_wr_t   mem_wr,
    output logic                 q_push,
    output lfifo_pkg::cmd_t      q_cmd,
    input  logic                 q_full,
    input  logic                 stream_done
);

    localparam int SLOT_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int LEN_W  = $clog2(LINE_BYTES + 1);
    localparam int OFF_W  = $clog2(LINE_BYTES);

    typedef enum logic {
        FS_IDLE,
        FS_POP
    } fstate_t;

    fstate_t                 state_reg, state_next;
    logic [SLOT_W-1:0]       read_slot_reg, read_slot_next;
    logic [SLOT_W-1:0]       write_slot_reg, write_slot_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [LEN_W-1:0]        off_reg, off_next;
    logic                    too_long_reg, too_long_next;
    logic                    was_full_reg, was_full_next;
    lfifo_pkg::len_t         limit_reg, limit_next;
    logic [lfifo_pkg::PEND_W-1:0] pend_reg, pend_next;

    // length memory, one entry per slot
    logic [LEN_W-1:0]        len_mem [QUEUE_DEPTH];
    logic [LEN_W-1:0]        len_rd_reg;
    logic                    len_we;

    logic                    accept;
    logic                    first_byte;
    logic                    is_full;
    logic                    was_full_eff;
    logic                    over;
    logic                    too_long_eff;
    logic [LEN_W-1:0]        off_inc;
    lfifo_pkg::len_t         len_ext;
    lfifo_pkg::len_t         pop_n;
    logic                    pend_inc;

    assign accept = in_valid && !in_stall;

    // pushes wait while any readout is pending: the freed slot may be the write slot
    assign in_stall = (state_reg != FS_IDLE) || q_full
                      || ((kind == lfifo_pkg::KIND_PUSH) && (pend_reg != '0));

    assign first_byte   = (off_reg == '0) && !too_long_reg;
    assign is_full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign was_full_eff = first_byte ? is_full : was_full_reg;
    assign over         = (off_reg >= LEN_W'(LINE_BYTES));
    assign too_long_eff = too_long_reg || over;
    assign off_inc      = off_reg + 1'b1;

    assign len_ext = lfifo_pkg::len_t'(len_rd_reg);
    assign pop_n   = (len_ext < limit_reg) ? len_ext : limit_reg;

    always_comb
    begin
        state_next      = state_reg;
        read_slot_next  = read_slot_reg;
        write_slot_next = write_slot_reg;
        count_next      = count_reg;
        off_next        = off_reg;
        too_long_next   = too_long_reg;
        was_full_next   = was_full_reg;
        limit_next      = limit_reg;
        pend_inc        = 1'b0;
        len_we          = 1'b0;
        q_push          = 1'b0;
        q_cmd           = '0;
        mem_wr          = '0;

        unique case (state_reg)
            FS_IDLE:
            begin
                if (accept && (kind == lfifo_pkg::KIND_PUSH))
                begin
                    mem_wr.en   = !over && !was_full_eff;
                    mem_wr.slot = lfifo_pkg::slot_ext_t'(write_slot_reg);
                    mem_wr.off  = lfifo_pkg::off_ext_t'(off_reg[OFF_W-1:0]);
                    mem_wr.data = push_byte;
                    if (push_last)
                    begin
                        q_push = 1'b1;
                        if (too_long_eff)
                        begin
                            q_cmd.status = lfifo_pkg::STATUS_PARAM;
                        end
                        else if (was_full_eff)
                        begin
                            q_cmd.status = lfifo_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            q_cmd.status    = lfifo_pkg::STATUS_OK;
                            len_we          = 1'b1;
                            write_slot_next = (write_slot_reg == SLOT_W'(QUEUE_DEPTH - 1))
                                              ? '0 : write_slot_reg + 1'b1;
                            count_next      = count_reg + 1'b1;
                        end
                        off_next      = '0;
                        too_long_next = 1'b0;
                        was_full_next = 1'b0;
                    end
                    else
                    begin
                        off_next      = over ? off_reg : off_inc;
                        too_long_next = too_long_eff;
                        was_full_next = was_full_eff;
                    end
                end
                else if (accept)
                begin
                    limit_next = pop_limit;
                    state_next = FS_POP;
                end
            end
            FS_POP:
            begin
                // length of the head line was read at the accept edge
                state_next = FS_IDLE;
                q_push     = 1'b1;
                if (limit_reg == '0)
                begin
                    q_cmd.status = lfifo_pkg::STATUS_PARAM;
                end
                else if (count_reg == '0)
                begin
                    q_cmd.status = lfifo_pkg::STATUS_EMPTY;
                end
                else
                begin
                    q_cmd.status   = lfifo_pkg::STATUS_OK;
                    q_cmd.stream   = 1'b1;
                    q_cmd.slot     = lfifo_pkg::slot_ext_t'(read_slot_reg);
                    q_cmd.count    = pop_n;
                    pend_inc       = 1'b1;
                    read_slot_next = (read_slot_reg == SLOT_W'(QUEUE_DEPTH - 1))
                                     ? '0 : read_slot_reg + 1'b1;
                    count_next     = count_reg - 1'b1;
                end
            end
        endcase

        // flags as they stand after this step
        q_cmd.q_empty = (count_next == '0);
        q_cmd.q_full  = (count_next == CNT_W'(QUEUE_DEPTH));

        unique case ({pend_inc, stream_done})
            2'b10:   pend_next = pend_reg + 1'b1;
            2'b01:   pend_next = pend_reg - 1'b1;
            default: pend_next = pend_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= FS_IDLE;
            read_slot_reg  <= '0;
            write_slot_reg <= '0;
            count_reg      <= '0;
            off_reg        <= '0;
            too_long_reg   <= 1'b0;
            was_full_reg   <= 1'b0;
            limit_reg      <= '0;
            pend_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            read_slot_reg  <= read_slot_next;
            write_slot_reg <= write_slot_next;
            count_reg      <= count_next;
            off_reg        <= off_next;
            too_long_reg   <= too_long_next;
            was_full_reg   <= was_full_next;
            limit_reg      <= limit_next;
            pend_reg       <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[write_slot_reg] <= off_inc;
        end
        len_rd_reg <= len_mem[read_slot_reg];
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("line count above queue depth");

    a_too_long_offset: assert property (@(posedge clk) disable iff (!rst_n)
        too_long_reg |-> (off_reg == LEN_W'(LINE_BYTES)))
        else $error("overlong line without offset held at line size");

    a_done_pending: assert property (@(posedge clk) disable iff (!rst_n)
        stream_done |-> (pend_reg != '0))
        else $error("readout finished with none pending");
`endif

endmodule

FILE: sv/lfifo_cmdq.sv
// Two-entry command queue between the front end and the readout back end.
`timescale 1ns / 1ps

module lfifo_cmdq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lfifo_pkg::cmd_t push_cmd,
    output logic            full,
    output logic            valid,
    output lfifo_pkg::cmd_t head_cmd,
    input  logic            pop
);

    localparam int PTR_W = $clog2(lfifo_pkg::CMDQ_DEPTH);
    localparam int CNT_W = $clog2(lfifo_pkg::CMDQ_DEPTH + 1);

    lfifo_pkg::cmd_t   ent_reg [lfifo_pkg::CMDQ_DEPTH];
    logic [PTR_W-1:0]  wp_reg, rp_reg;
    logic [CNT_W-1:0]  cnt_reg;

    assign valid    = (cnt_reg != '0);
    assign full     = (cnt_reg == CNT_W'(lfifo_pkg::CMDQ_DEPTH));
    assign head_cmd = ent_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == PTR_W'(lfifo_pkg::CMDQ_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == PTR_W'(lfifo_pkg::CMDQ_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wp_reg] <= push_cmd;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("command queue underflow");
`endif

endmodule

FILE: sv/lfifo_back.sv
// Back end: line store, byte readout pipeline and output register.
`timescale 1ns / 1ps

module lfifo_back #(
    parameter int QUEUE_DEPTH = 8,
    parameter int LINE_BYTES  = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lfifo_pkg::mem_wr_t mem_wr,
    input  logic               q_valid,
    input  lfifo_pkg::cmd_t    q_cmd,
    output logic               q_pop,
    output logic               stream_done,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic               byte_valid,
    output logic [7:0]         out_byte,
    output logic               last,
    output logic [6:0]         delivered_length,
    output logic               queue_empty,
    output logic               queue_full
);

    localparam int SLOT_W    = $clog2(QUEUE_DEPTH);
    localparam int LEN_W     = $clog2(LINE_BYTES + 1);
    localparam int OFF_W     = $clog2(LINE_BYTES);
    localparam int MEM_DEPTH = QUEUE_DEPTH << OFF_W;
    localparam int ADDR_W    = SLOT_W + OFF_W;

    typedef enum logic {
        BS_IDLE,
        BS_STREAM
    } bstate_t;

    bstate_t            state_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [LEN_W-1:0]   idx_reg;
    lfifo_pkg::len_t    n_reg;
    logic               empty_reg, full_reg;

    logic               v1_reg;
    lfifo_pkg::res_t    s1_reg;

    logic               out_valid_reg;
    lfifo_pkg::res_t    out_reg;
    logic [7:0]         out_byte_reg;

    logic [7:0]         line_mem [MEM_DEPTH];
    logic [7:0]         rd_data_reg;

    logic               advance;
    logic               s1_load;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic               final_byte;

    assign advance    = !out_valid_reg || !out_stall;
    assign s1_load    = !v1_reg || advance;
    assign rd_en      = s1_load && (state_reg == BS_STREAM);
    assign rd_addr    = {slot_reg, idx_reg[OFF_W-1:0]};
    assign wr_addr    = {mem_wr.slot[SLOT_W-1:0], mem_wr.off[OFF_W-1:0]};
    assign final_byte = ((lfifo_pkg::len_t'(idx_reg) + 1'b1) == n_reg);
    assign q_pop      = s1_load && (state_reg == BS_IDLE) && q_valid;
    assign stream_done = rd_en && final_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_IDLE;
            slot_reg      <= '0;
            idx_reg       <= '0;
            n_reg         <= '0;
            empty_reg     <= 1'b0;
            full_reg      <= 1'b0;
            v1_reg        <= 1'b0;
            s1_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            out_byte_reg  <= '0;
        end
        else
        begin
            if (s1_load)
            begin
                unique case (state_reg)
                    BS_STREAM:
                    begin
                        v1_reg            <= 1'b1;
                        s1_reg.status     <= lfifo_pkg::STATUS_OK;
                        s1_reg.byte_valid <= 1'b1;
                        s1_reg.last       <= final_byte;
                        s1_reg.len        <= final_byte ? n_reg : '0;
                        s1_reg.q_empty    <= empty_reg;
                        s1_reg.q_full     <= full_reg;
                        idx_reg           <= idx_reg + 1'b1;
                        if (final_byte)
                        begin
                            state_reg <= BS_IDLE;
                        end
                    end
                    BS_IDLE:
                    begin
                        if (q_valid && q_cmd.stream)
                        begin
                            v1_reg    <= 1'b0;
                            state_reg <= BS_STREAM;
                            slot_reg  <= q_cmd.slot[SLOT_W-1:0];
                            idx_reg   <= '0;
                            n_reg     <= q_cmd.count;
                            empty_reg <= q_cmd.q_empty;
                            full_reg  <= q_cmd.q_full;
                        end
                        else if (q_valid)
                        begin
                            v1_reg            <= 1'b1;
                            s1_reg.status     <= q_cmd.status;
                            s1_reg.byte_valid <= 1'b0;
                            s1_reg.last       <= 1'b1;
                            s1_reg.len        <= '0;
                            s1_reg.q_empty    <= q_cmd.q_empty;
                            s1_reg.q_full     <= q_cmd.q_full;
                        end
                        else
                        begin
                            v1_reg <= 1'b0;
                        end
                    end
                endcase
            end

            if (advance)
            begin
                out_valid_reg <= v1_reg;
                out_reg       <= s1_reg;
                out_byte_reg  <= s1_reg.byte_valid ? rd_data_reg : 8'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr.en)
        begin
            line_mem[wr_addr] <= mem_wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = out_reg.status;
    assign byte_valid       = out_reg.byte_valid;
    assign out_byte         = out_byte_reg;
    assign last             = out_reg.last;
    assign delivered_length = out_reg.len;
    assign queue_empty      = out_reg.q_empty;
    assign queue_full       = out_reg.q_full;

endmodule

FILE: sv/line_fifo_with_truncating_pop.sv
// Top level of the line FIFO with truncating pop.
`timescale 1ns / 1ps

// Circular FIFO of up to QUEUE_DEPTH byte lines, each at most LINE_BYTES long.
// A push transfer carries one byte (kind=0) and push_last marks the line end; the
// line end gives one status result (ok, parameter error when the line overflowed,
// full when the queue was full at its first byte) and rejected lines are dropped.
// A pop transfer (kind=1) streams the first min(length, pop_limit) bytes of the head
// line, one result per byte, with last and delivered_length on the final byte; a zero
// limit gives a parameter error and an empty queue gives an empty status. Every result
// carries the empty and full flags as they stand after its input. Timing: push bytes
// are taken one per cycle while in_stall is low; the front takes a pop in FS_IDLE, where
// the head line's length is read from the length memory, and issues its command from
// FS_POP; the back then reads the line store at one byte per cycle, unless out_stall
// holds it, through a two-stage pipeline (registered memory read, then output register).
// Push transfers are held off (in_stall) while any readout is queued or running, since
// the slot being read may be the next one written. A status result passes through the
// command queue, the stage-one register and the output register. The output register
// lets new items be taken while a result waits on out_stall.
module line_fifo_with_truncating_pop #(
    parameter int QUEUE_DEPTH = 8,
    parameter int LINE_BYTES  = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic [7:0] push_byte,
    input  logic       push_last,
    input  logic [6:0] pop_limit,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic       byte_valid,
    output logic [7:0] out_byte,
    output logic       last,
    output logic [6:0] delivered_length,
    output logic       queue_empty,
    output logic       queue_full
);

    lfifo_pkg::mem_wr_t mem_wr;
    lfifo_pkg::cmd_t    front_cmd;
    lfifo_pkg::cmd_t    head_cmd;
    logic               cmd_push;
    logic               cmd_full;
    logic               cmd_valid;
    logic               cmd_pop;
    logic               stream_done;

    // front: line assembly, slot pointers, line count, pop decisions
    lfifo_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .LINE_BYTES  (LINE_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .push_byte   (push_byte),
        .push_last   (push_last),
        .pop_limit   (pop_limit),
        .mem_wr      (mem_wr),
        .q_push      (cmd_push),
        .q_cmd       (front_cmd),
        .q_full      (cmd_full),
        .stream_done (stream_done)
    );

    // short queue so front and back stall independently
    lfifo_cmdq u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (front_cmd),
        .full     (cmd_full),
        .valid    (cmd_valid),
        .head_cmd (head_cmd),
        .pop      (cmd_pop)
    );

    // back: line store and result streaming
    lfifo_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .LINE_BYTES  (LINE_BYTES)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .mem_wr           (mem_wr),
        .q_valid          (cmd_valid),
        .q_cmd            (head_cmd),
        .q_pop            (cmd_pop),
        .stream_done      (stream_done),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .byte_valid       (byte_valid),
        .out_byte         (out_byte),
        .last             (last),
        .delivered_length (delivered_length),
        .queue_empty      (queue_empty),
        .queue_full       (queue_full)
    );

endmodule

FILE: sim/tb_line_fifo_with_truncating_pop.sv
// Self-checking testbench for the line FIFO with truncating pop.
`timescale 1ns / 1ps

module tb_line_fifo_with_truncating_pop;

    localparam int QUEUE_DEPTH  = 8;
    localparam int LINE_BYTES   = 64;
    localparam int RANDOM_ITEMS = 310;
    localparam int HOLD_AT      = 160;     // item count at which the receiver holds off
    localparam int HOLD_CYCLES  = 400;
    localparam int PAUSE_AT     = 260;     // item count at which the sender drains the queue
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;

    // One result transfer as seen on the output channel
    typedef struct packed {
        logic [1:0] status;
        logic       byte_valid;
        logic [7:0] out_byte;
        logic       last;
        logic [6:0] length;
        logic       empty;
        logic       full;
    } line_result_t;

    // Predicts results of the line queue and checks them in order
    class line_fifo_scoreboard;
        logic [7:0]   line_mem [QUEUE_DEPTH][LINE_BYTES];
        logic [6:0]   line_len [QUEUE_DEPTH];
        int unsigned  head, tail, count, offset;
        bit           too_long, was_full;
        line_result_t expected [$];
        int           mismatches;

        function new();
            head = 0;
            tail = 0;
            count = 0;
            offset = 0;
            too_long = 0;
            was_full = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        // Flags reflect the queue after the step, so call after state updates
        function void add_expected(logic [1:0] st, bit bv, logic [7:0] b, bit fin,
                                   logic [6:0] n);
            line_result_t r;
            r.status     = st;
            r.byte_valid = bv;
            r.out_byte   = b;
            r.last       = fin;
            r.length     = n;
            r.empty      = (count == 0);
            r.full       = (count >= QUEUE_DEPTH);
            expected.push_back(r);
        endfunction

        function void note_transfer(bit k, logic [7:0] b, bit l, logic [6:0] lim);
            int unsigned n;
            int unsigned slot;
            logic [1:0]  st;
            if (k == lfifo_pkg::KIND_PUSH)
            begin
                // full check is latched on the first byte of a line
                if (offset == 0 && !too_long)
                    was_full = (count >= QUEUE_DEPTH);
                if (offset >= LINE_BYTES)
                    too_long = 1;
                else
                begin
                    if (!was_full)
                        line_mem[tail][offset] = b;
                    offset++;
                end
                if (l)
                begin
                    if (too_long)
                        st = lfifo_pkg::STATUS_PARAM;
                    else if (was_full)
                        st = lfifo_pkg::STATUS_FULL;
                    else
                    begin
                        line_len[tail] = 7'(offset);
                        tail = (tail + 1) % QUEUE_DEPTH;
                        count++;
                        st = lfifo_pkg::STATUS_OK;
                    end
                    offset = 0;
                    too_long = 0;
                    was_full = 0;
                    add_expected(st, 1'b0, 8'h00, 1'b1, 7'd0);
                end
            end
            else if (lim == 0)
                add_expected(lfifo_pkg::STATUS_PARAM, 1'b0, 8'h00, 1'b1, 7'd0);
            else if (count == 0)
                add_expected(lfifo_pkg::STATUS_EMPTY, 1'b0, 8'h00, 1'b1, 7'd0);
            else
            begin
                n = line_len[head];
                if (n > lim)
                    n = lim;
                slot = head;
                head = (head + 1) % QUEUE_DEPTH;
                count--;
                for (int i = 0; i < n; i++)
                    add_expected(lfifo_pkg::STATUS_OK, 1'b1, line_mem[slot][i], i == n - 1,
                                 (i == n - 1) ? 7'(n) : 7'd0);
            end
        endfunction

        function string show(line_result_t r);
            return $sformatf("st=%0d bv=%0d byte=%02h last=%0d len=%0d empty=%0d full=%0d",
                             r.status, r.byte_valid, r.out_byte, r.last, r.length,
                             r.empty, r.full);
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t mismatch: %s", $time, what);
        endfunction

        function void check_result(line_result_t got);
            line_result_t want;
            if (expected.size() == 0)
            begin
                report({"result with nothing expected: ", show(got)});
                return;
            end
            want = expected.pop_front();
            if (got.status !== want.status || got.byte_valid !== want.byte_valid ||
                got.out_byte !== want.out_byte || got.last !== want.last ||
                got.length !== want.length || got.empty !== want.empty ||
                got.full !== want.full)
                report({"expected ", show(want), " got ", show(got)});
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       kind;
    logic [7:0] push_byte;
    logic       push_last;
    logic [6:0] pop_limit;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] status;
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       last;
    logic [6:0] delivered_length;
    logic       queue_empty;
    logic       queue_full;

    line_fifo_scoreboard sb;
    int unsigned items_sent;
    int unsigned idle_pct;      // chance the sender skips a cycle
    int unsigned stall_pct;     // chance the receiver stalls a cycle
    int unsigned hold_left;
    bit          hold_done;
    bit          paused;

    line_fifo_with_truncating_pop #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .LINE_BYTES (LINE_BYTES)
    ) dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    // Receiver: checks each result transfer, then picks next cycle's stall.
    // A single long hold-off backs the block up so that it stalls its input.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result({status, byte_valid, out_byte, last, delivered_length,
                                 queue_empty, queue_full});
            if (!hold_done && items_sent >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Offers one item and returns at the edge where it is transferred.
    // Valid is left high; the next call or an idle cycle decides its value.
    task automatic send_item(bit k, logic [7:0] b, bit l, logic [6:0] lim);
        case ((items_sent / 40) % 4)
            0:
            begin
                idle_pct = 0;
                stall_pct = 0;
            end
            1:
            begin
                idle_pct = 83;
                stall_pct = 0;
            end
            2:
            begin
                idle_pct = 0;
                stall_pct = 83;
            end
            default:
            begin
                idle_pct = 24;
                stall_pct = 24;
            end
        endcase
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        push_byte <= b;
        push_last <= l;
        pop_limit <= lim;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_transfer(k, b, l, lim);
        items_sent++;
    endtask

    function automatic logic [6:0] random_limit();
        return $urandom_range(1) ? 7'($urandom_range(1, 8)) : 7'($urandom_range(1, LINE_BYTES));
    endfunction

    // Unused fields of a pop carry random values
    task automatic send_pop(logic [6:0] lim);
        send_item(lfifo_pkg::KIND_POP, 8'($urandom_range(255)), 1'($urandom_range(1)), lim);
    endtask

    // Pushes one line of len bytes; a pop is slipped in before byte pop_at
    task automatic send_line(int len, int pop_at);
        for (int i = 0; i < len; i++)
        begin
            if (i == pop_at)
                send_pop(random_limit());
            send_item(lfifo_pkg::KIND_PUSH, 8'($urandom_range(255)), i == len - 1,
                      7'($urandom_range(LINE_BYTES)));
        end
    endtask

    // One line more than the queue holds; the extra line frees a slot mid-way,
    // which must not lift its full rejection
    task automatic fill_queue();
        for (int j = 0; j < QUEUE_DEPTH; j++)
            send_line($urandom_range(1, 3), -1);
        send_line($urandom_range(2, 4), 1);
    endtask

    initial
    begin
        int unsigned pick;
        int          len;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        kind       = lfifo_pkg::KIND_PUSH;
        push_byte  = 8'h00;
        push_last  = 1'b0;
        pop_limit  = 7'd0;
        out_stall  = 1'b0;
        items_sent = 0;
        idle_pct   = 0;
        stall_pct  = 0;
        hold_left  = 0;
        hold_done  = 0;
        paused     = 0;
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty pop, zero limit, byte extremes, pop during line
        // assembly, truncated pop, limit above the line length
        send_item(lfifo_pkg::KIND_POP,  8'h00, 1'b0, 7'd5);
        send_item(lfifo_pkg::KIND_POP,  8'hFF, 1'b1, 7'd0);
        send_item(lfifo_pkg::KIND_PUSH, 8'hFF, 1'b1, 7'd64);
        send_item(lfifo_pkg::KIND_PUSH, 8'h00, 1'b0, 7'd0);
        send_item(lfifo_pkg::KIND_PUSH, 8'hA5, 1'b0, 7'd0);
        send_item(lfifo_pkg::KIND_PUSH, 8'h5A, 1'b1, 7'd0);
        send_item(lfifo_pkg::KIND_PUSH, 8'h11, 1'b0, 7'd63);
        send_item(lfifo_pkg::KIND_POP,  8'h00, 1'b0, 7'd64);
        send_item(lfifo_pkg::KIND_PUSH, 8'h22, 1'b1, 7'd0);
        send_item(lfifo_pkg::KIND_POP,  8'h00, 1'b0, 7'd2);
        send_item(lfifo_pkg::KIND_POP,  8'h00, 1'b0, 7'd0);
        send_item(lfifo_pkg::KIND_POP,  8'h00, 1'b0, 7'd64);
        send_item(lfifo_pkg::KIND_POP,  8'h00, 1'b0, 7'd1);

        // An overlong line and a full queue come first, then the random mix
        send_line(LINE_BYTES + 2, -1);
        fill_queue();
        send_line(LINE_BYTES, -1);
        while (items_sent < RANDOM_ITEMS)
        begin
            if (!paused && items_sent >= PAUSE_AT)
            begin
                paused = 1;
                while (sb.pending() != 0)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                end
            end
            pick = $urandom_range(99);
            if (pick < 3)
                send_line(LINE_BYTES + $urandom_range(1, 4), -1);
            else if (pick < 7)
                fill_queue();
            else if (pick < 50)
            begin
                if ($urandom_range(9) == 0)
                    len = $urandom_range(3) == 0 ? LINE_BYTES : $urandom_range(9, LINE_BYTES);
                else
                    len = $urandom_range(1, 8);
                send_line(len, ($urandom_range(5) == 0) ? int'($urandom_range(len - 1)) : -1);
            end
            else if (pick < 94)
                send_pop(random_limit());
            else
                send_pop(7'd0);
        end

        // Drain with the receiver always ready
        in_valid <= 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: line_fifo_with_truncating_pop.f
sv/lfifo_pkg.sv
sv/lfifo_front.sv
sv/lfifo_cmdq.sv
sv/lfifo_back.sv
sv/line_fifo_with_truncating_pop.sv
sim/tb_line_fifo_with_truncating_pop.sv
